### hw/rtl/mfqs_pkg.sv
// mfqs_pkg: shared types and constants for the multilevel feedback queue set
// request codes, status codes, controller states and the command bundle
// no dependencies
`timescale 1ns / 1ps

package mfqs_pkg;

  localparam int NUM_PROCS = 64;
  localparam int PID_W     = 6;
  localparam int LVL_IN_W  = 2;
  localparam int TICK_W    = 32;
  localparam int REQ_W     = 3;
  localparam int ST_W      = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ  = 3'd0,
    REQ_DEQ  = 3'd1,
    REQ_REM  = 3'd2,
    REQ_DEM  = 3'd3,
    REQ_PRO  = 3'd4,
    REQ_REIN = 3'd5
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_NOTQ  = 3'd3,
    ST_DUP   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic load_req;
    logic load_lkp;
    logic commit;
  } cmd_t;

endpackage

### hw/rtl/mfqs_ram.sv
// mfqs_ram: generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module mfqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/mfqs_dp.sv
// mfqs_dp: datapath with the per-level collapsing queues, per-process marks,
// level/stamp ram and the result register; depends on mfqs_pkg and mfqs_ram
`timescale 1ns / 1ps

module mfqs_dp #(
  parameter int NUM_LEVELS  = 4,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mfqs_pkg::cmd_t                cmd,
  input  logic [mfqs_pkg::REQ_W-1:0]    in_req_type,
  input  logic [mfqs_pkg::PID_W-1:0]    in_proc_id,
  input  logic [mfqs_pkg::LVL_IN_W-1:0] in_level,
  input  logic [mfqs_pkg::TICK_W-1:0]   in_now_tick,
  input  logic                          in_runnable,
  output logic [mfqs_pkg::ST_W-1:0]     out_status,
  output logic [mfqs_pkg::PID_W-1:0]    out_out_proc,
  output logic [mfqs_pkg::LVL_IN_W-1:0] out_out_level,
  output logic [mfqs_pkg::TICK_W-1:0]   out_out_enq_tick,
  output logic                          out_clear_run_count
);
  import mfqs_pkg::*;

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int RW = LW + TICK_W;

  // queue cells, counts and per-process state
  logic [PID_W-1:0]     cell_r   [NUM_LEVELS][QUEUE_DEPTH];
  logic [PID_W-1:0]     cell_nxt [NUM_LEVELS][QUEUE_DEPTH];
  logic [CW-1:0]        cnt_r    [NUM_LEVELS];
  logic [CW-1:0]        cnt_nxt  [NUM_LEVELS];
  logic [NUM_PROCS-1:0] queued_r, queued_nxt;
  logic [NUM_PROCS-1:0] ram_vld_r, ram_vld_nxt;

  // captured request
  logic [REQ_W-1:0]  req_r;
  logic [PID_W-1:0]  pid_r;
  logic [LW-1:0]     lv_r;
  logic [TICK_W-1:0] now_r;
  logic              run_r;
  logic [PID_W-1:0]  hd_r;
  logic              rd_vld_r;

  // lookup results
  logic [LW-1:0]     cur_r;
  logic [TICK_W-1:0] tick_r;
  logic [IW-1:0]     idx_r;

  // result register
  logic [ST_W-1:0]     st_r;
  logic [PID_W-1:0]    op_r;
  logic [LVL_IN_W-1:0] ol_r;
  logic [TICK_W-1:0]   ot_r;
  logic                clr_r;

  // ---------------- request capture ----------------
  logic [LW-1:0]    lv_in;
  logic [PID_W-1:0] head_in;
  logic [PID_W-1:0] raddr;

  always_comb begin
    if (int'(in_level) >= NUM_LEVELS) begin
      lv_in = LW'(NUM_LEVELS - 1);
    end else begin
      lv_in = LW'(in_level);
    end
    head_in = cell_r[lv_in][0];
    // dequeue looks up the stamp of the head entry
    raddr = (in_req_type == REQ_DEQ) ? head_in : in_proc_id;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r    <= in_req_type;
      pid_r    <= in_proc_id;
      lv_r     <= lv_in;
      now_r    <= in_now_tick;
      run_r    <= in_runnable;
      hd_r     <= head_in;
      rd_vld_r <= ram_vld_r[raddr];
    end
  end

  // ---------------- level / stamp ram ----------------
  logic          ram_we;
  logic [RW-1:0] ram_wdata;
  logic [RW-1:0] ram_rdata;

  mfqs_ram #(
    .WIDTH(RW),
    .DEPTH(NUM_PROCS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(pid_r),
    .wdata(ram_wdata),
    .re   (cmd.load_req),
    .raddr(raddr),
    .rdata(ram_rdata)
  );

  // ---------------- lookup ----------------
  logic [LW-1:0]          rd_lvl;
  logic [TICK_W-1:0]      rd_tick;
  logic [LW-1:0]          srch_lvl;
  logic [PID_W-1:0]       srch_id;
  logic [QUEUE_DEPTH-1:0] match;
  logic [IW-1:0]          idx_c;

  always_comb begin
    // never-written entries read as the reset value
    rd_lvl   = rd_vld_r ? ram_rdata[RW-1:TICK_W] : '0;
    rd_tick  = rd_vld_r ? ram_rdata[TICK_W-1:0] : '0;
    srch_lvl = (req_r == REQ_DEQ) ? lv_r : rd_lvl;
    srch_id  = (req_r == REQ_DEQ) ? hd_r : pid_r;
    idx_c    = '0;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      match[j] = (cell_r[srch_lvl][j] == srch_id) && (CW'(j) < cnt_r[srch_lvl]);
    end
    // a process sits at most once in a level, so at most one match bit is set
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (match[j]) begin
        idx_c = idx_c | IW'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_lkp) begin
      cur_r  <= rd_lvl;
      tick_r <= rd_tick;
      idx_r  <= idx_c;
    end
  end

  // ---------------- execute ----------------
  status_t          st;
  logic [PID_W-1:0] op;
  logic [LW-1:0]    ol;
  logic [TICK_W-1:0] ot;
  logic             clr;
  logic             rm, app, set_q, clr_q, wr;
  logic [LW-1:0]    rm_lv, app_lv, tgt;
  logic [PID_W-1:0] q_id;
  logic             queued;

  always_comb begin
    st     = ST_OK;
    op     = '0;
    ol     = '0;
    ot     = '0;
    clr    = 1'b0;
    rm     = 1'b0;
    app    = 1'b0;
    set_q  = 1'b0;
    clr_q  = 1'b0;
    wr     = 1'b0;
    rm_lv  = cur_r;
    app_lv = cur_r;
    q_id   = pid_r;
    queued = queued_r[pid_r];
    tgt    = cur_r;
    if (req_r == REQ_DEM) begin
      if (cur_r != LW'(NUM_LEVELS - 1)) begin
        tgt = cur_r + 1'b1;
      end
    end else if (cur_r != '0) begin
      tgt = cur_r - 1'b1;
    end
    unique case (req_r)
      REQ_ENQ: begin
        op = pid_r;
        if (queued) begin
          st = ST_DUP;
          ol = cur_r;
          ot = tick_r;
        end else if (cnt_r[lv_r] == CW'(QUEUE_DEPTH)) begin
          st = ST_FULL;
          ol = lv_r;
        end else begin
          app    = 1'b1;
          app_lv = lv_r;
          set_q  = 1'b1;
          wr     = 1'b1;
          ol     = lv_r;
          ot     = now_r;
        end
      end
      REQ_DEQ: begin
        ol = lv_r;
        if (cnt_r[lv_r] == '0) begin
          st = ST_EMPTY;
        end else begin
          rm    = 1'b1;
          rm_lv = lv_r;
          clr_q = 1'b1;
          q_id  = hd_r;
          op    = hd_r;
          ot    = tick_r;
        end
      end
      REQ_REM, REQ_DEM, REQ_PRO, REQ_REIN: begin
        op = pid_r;
        ol = cur_r;
        ot = tick_r;
        if (!queued) begin
          st = ST_NOTQ;
        end else if (req_r == REQ_REM) begin
          rm    = 1'b1;
          clr_q = 1'b1;
        end else if (req_r == REQ_REIN) begin
          rm = 1'b1;
          if (run_r) begin
            app = 1'b1;
          end else begin
            clr_q = 1'b1;
          end
        end else begin
          ol = tgt;
          if (tgt != cur_r && cnt_r[tgt] == CW'(QUEUE_DEPTH)) begin
            st = ST_FULL;
          end else begin
            rm     = 1'b1;
            app    = 1'b1;
            app_lv = tgt;
            wr     = 1'b1;
            ot     = now_r;
            clr    = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_we    = cmd.commit && wr;
  assign ram_wdata = {app_lv, now_r};

  // collapse on removal, then write the appended id at the new tail
  always_comb begin
    logic          rm_l, app_l;
    logic [CW-1:0] cnt1;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      rm_l  = rm && (rm_lv == LW'(l));
      app_l = app && (app_lv == LW'(l));
      cnt1  = cnt_r[l] - CW'(rm_l);
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
        cell_nxt[l][j] = cell_r[l][j];
        if (rm_l && IW'(j) >= idx_r && j < QUEUE_DEPTH - 1) begin
          cell_nxt[l][j] = cell_r[l][(j < QUEUE_DEPTH - 1) ? j + 1 : j];
        end
        if (app_l && CW'(j) == cnt1) begin
          cell_nxt[l][j] = pid_r;
        end
      end
      cnt_nxt[l] = cnt1 + CW'(app_l);
    end
    queued_nxt = queued_r;
    if (set_q) begin
      queued_nxt[q_id] = 1'b1;
    end
    if (clr_q) begin
      queued_nxt[q_id] = 1'b0;
    end
    ram_vld_nxt = ram_vld_r;
    if (wr) begin
      ram_vld_nxt[pid_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        for (int j = 0; j < QUEUE_DEPTH; j++) begin
          cell_r[l][j] <= cell_nxt[l][j];
        end
      end
      st_r  <= st;
      op_r  <= op;
      ol_r  <= LVL_IN_W'(ol);
      ot_r  <= ot;
      clr_r <= clr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        cnt_r[l] <= '0;
      end
      queued_r  <= '0;
      ram_vld_r <= '0;
    end else if (cmd.commit) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        cnt_r[l] <= cnt_nxt[l];
      end
      queued_r  <= queued_nxt;
      ram_vld_r <= ram_vld_nxt;
    end
  end

  assign out_status          = st_r;
  assign out_out_proc        = op_r;
  assign out_out_level       = ol_r;
  assign out_out_enq_tick    = ot_r;
  assign out_clear_run_count = clr_r;

  // a process is found at most once in the searched level
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_lkp |=> $onehot0(match))
    else $error("mfqs_dp: process found more than once in a level");

endmodule

### hw/rtl/mfqs_ctrl.sv
// mfqs_ctrl: controller state machine sequencing capture, lookup and commit,
// and owning the result valid flag; depends on mfqs_pkg
`timescale 1ns / 1ps

module mfqs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output mfqs_pkg::cmd_t cmd
);
  import mfqs_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.load_req = 1'b0;
    cmd.load_lkp = 1'b0;
    cmd.commit   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      S_LOOKUP: begin
        cmd.load_lkp = 1'b1;
      end
      S_EXEC: begin
        cmd.commit = slot_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("mfqs_ctrl: commit overwrote a pending result");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_LOOKUP))
    else $error("mfqs_ctrl: accepted request did not start a lookup");

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("mfqs_ctrl: commit did not raise result valid");

endmodule

### hw/rtl/multilevel_feedback_queue_set_top.sv
// channel | signals                                          | direction
// in      | in_valid/in_ready, req_type proc_id level
//         | now_tick runnable                                | request in
// out     | out_valid/out_ready, status out_proc out_level
//         | out_enq_tick clear_run_count                     | result out
//
// each request passes through accept (stamp ram read issued), lookup
// (registered ram data, search of the level), commit (queue collapse/append)
// commit waits while the result register still holds an untaken result;
// a new request is accepted while a result waits
// synchronous active-low reset clears counts and marks; no clearing pass
// depends on mfqs_pkg, mfqs_ctrl, mfqs_dp
`timescale 1ns / 1ps

module multilevel_feedback_queue_set_top #(
  parameter int NUM_LEVELS  = 4,
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mfqs_pkg::REQ_W-1:0]    in_req_type,
  input  logic [mfqs_pkg::PID_W-1:0]    in_proc_id,
  input  logic [mfqs_pkg::LVL_IN_W-1:0] in_level,
  input  logic [mfqs_pkg::TICK_W-1:0]   in_now_tick,
  input  logic                          in_runnable,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mfqs_pkg::ST_W-1:0]     out_status,
  output logic [mfqs_pkg::PID_W-1:0]    out_out_proc,
  output logic [mfqs_pkg::LVL_IN_W-1:0] out_out_level,
  output logic [mfqs_pkg::TICK_W-1:0]   out_out_enq_tick,
  output logic                          out_clear_run_count
);
  import mfqs_pkg::*;

  cmd_t cmd;

  mfqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  mfqs_dp #(
    .NUM_LEVELS (NUM_LEVELS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_req_type        (in_req_type),
    .in_proc_id         (in_proc_id),
    .in_level           (in_level),
    .in_now_tick        (in_now_tick),
    .in_runnable        (in_runnable),
    .out_status         (out_status),
    .out_out_proc       (out_out_proc),
    .out_out_level      (out_out_level),
    .out_out_enq_tick   (out_out_enq_tick),
    .out_clear_run_count(out_clear_run_count)
  );

endmodule

### tb/multilevel_feedback_queue_set_top_tb.sv
// testbench for multilevel_feedback_queue_set_top: directed and random scheduler requests
// checked against an in-bench queue-set predictor; depends on mfqs_pkg and the top level
`timescale 1ns / 1ps

module multilevel_feedback_queue_set_top_tb;
  import mfqs_pkg::*;

  localparam int LEVELS = 4;
  localparam int DEPTH  = 64;

  // request codes outside the defined set, expected to be ignored
  localparam int REQ_UNUSED_0 = 6;
  localparam int REQ_UNUSED_1 = 7;

  typedef struct {
    logic [REQ_W-1:0]    req;
    logic [PID_W-1:0]    pid;
    logic [LVL_IN_W-1:0] lvl;
    logic [TICK_W-1:0]   tick;
    logic                run;
  } sched_req_t;

  typedef struct {
    logic [ST_W-1:0]     st;
    logic [PID_W-1:0]    pid;
    logic [LVL_IN_W-1:0] lvl;
    logic [TICK_W-1:0]   tick;
    logic                clr;
  } sched_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] in_req_type = '0;
  logic [PID_W-1:0] in_proc_id = '0;
  logic [LVL_IN_W-1:0] in_level = '0;
  logic [TICK_W-1:0] in_now_tick = '0;
  logic in_runnable = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ST_W-1:0] out_status;
  logic [PID_W-1:0] out_out_proc;
  logic [LVL_IN_W-1:0] out_out_level;
  logic [TICK_W-1:0] out_out_enq_tick;
  logic out_clear_run_count;

  multilevel_feedback_queue_set_top dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [PID_W-1:0]  lvl_q [LEVELS][$];
  logic              pq_queued [NUM_PROCS];
  logic [1:0]        pq_level [NUM_PROCS];
  logic [TICK_W-1:0] pq_tick [NUM_PROCS];

  sched_req_t pending_reqs[$];
  sched_rsp_t expected_rsps[$];
  int errors = 0;
  bit feeding_done = 0;
  bit no_idle = 0;
  logic [TICK_W-1:0] tick_now = '0;

  function automatic void take_out(int lv, logic [PID_W-1:0] p);
    for (int i = 0; i < lvl_q[lv].size(); i++)
      if (lvl_q[lv][i] == p) begin
        lvl_q[lv].delete(i);
        return;
      end
  endfunction

  function automatic sched_rsp_t predict_sched(sched_req_t r);
    sched_rsp_t o;
    int lv, cur, tgt;
    logic [PID_W-1:0] h;
    o = '{ST_OK, '0, '0, '0, 1'b0};
    lv = int'(r.lvl);
    if (r.req == REQ_ENQ) begin
      o.pid = r.pid;
      if (pq_queued[r.pid]) begin
        o.st = ST_DUP; o.lvl = pq_level[r.pid]; o.tick = pq_tick[r.pid];
      end else if (lvl_q[lv].size() >= DEPTH) begin
        o.st = ST_FULL; o.lvl = LVL_IN_W'(lv);
      end else begin
        lvl_q[lv].push_back(r.pid);
        pq_queued[r.pid] = 1; pq_level[r.pid] = LVL_IN_W'(lv); pq_tick[r.pid] = r.tick;
        o.lvl = LVL_IN_W'(lv); o.tick = r.tick;
      end
    end else if (r.req == REQ_DEQ) begin
      o.lvl = LVL_IN_W'(lv);
      if (lvl_q[lv].size() == 0) o.st = ST_EMPTY;
      else begin
        h = lvl_q[lv].pop_front();
        pq_queued[h] = 0;
        o.pid = h; o.tick = pq_tick[h];
      end
    end else if (r.req <= REQ_REIN) begin
      cur = int'(pq_level[r.pid]);
      o.pid = r.pid; o.lvl = LVL_IN_W'(cur); o.tick = pq_tick[r.pid];
      if (!pq_queued[r.pid]) o.st = ST_NOTQ;
      else if (r.req == REQ_REM) begin
        take_out(cur, r.pid); pq_queued[r.pid] = 0;
      end else if (r.req == REQ_REIN) begin
        take_out(cur, r.pid);
        if (r.run) lvl_q[cur].push_back(r.pid);
        else pq_queued[r.pid] = 0;
      end else begin
        tgt = cur;
        if (r.req == REQ_DEM) begin
          if (cur + 1 < LEVELS) tgt = cur + 1;
        end else if (cur > 0) tgt = cur - 1;
        o.lvl = LVL_IN_W'(tgt);
        if (tgt != cur && lvl_q[tgt].size() >= DEPTH) o.st = ST_FULL;
        else begin
          take_out(cur, r.pid);
          lvl_q[tgt].push_back(r.pid);
          pq_level[r.pid] = LVL_IN_W'(tgt); pq_tick[r.pid] = r.tick;
          o.tick = r.tick; o.clr = 1;
        end
      end
    end
    return o;
  endfunction

  function automatic void add_req(int rq, int p, int lv, int run);
    sched_req_t r;
    tick_now += $urandom_range(0, 3);
    r.req = REQ_W'(rq); r.pid = PID_W'(p); r.lvl = LVL_IN_W'(lv); r.tick = tick_now;
    r.run = 1'(run);
    pending_reqs.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 34)) begin
          sched_req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= r.req; in_proc_id <= r.pid; in_level <= r.lvl;
          in_now_tick <= r.tick; in_runnable <= r.run;
          expected_rsps.push_back(predict_sched(r));
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= no_idle || ($urandom_range(0, 99) >= 34);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result status=%0d proc=%0d", $time, out_status,
                 out_out_proc);
        errors++;
      end else begin
        sched_rsp_t e;
        e = expected_rsps.pop_front();
        if (out_status !== e.st || out_out_proc !== e.pid || out_out_level !== e.lvl ||
            out_out_enq_tick !== e.tick || out_clear_run_count !== e.clr) begin
          $display("%0t: mismatch expected st=%0d proc=%0d lvl=%0d tick=%h clr=%0d",
                   $time, e.st, e.pid, e.lvl, e.tick, e.clr);
          $display("%0t:          actual   st=%0d proc=%0d lvl=%0d tick=%h clr=%0d",
                   $time, out_status, out_out_proc, out_out_level, out_out_enq_tick,
                   out_clear_run_count);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int k, sel, p;
    for (int i = 0; i < NUM_PROCS; i++) begin
      pq_queued[i] = 0; pq_level[i] = 0; pq_tick[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty dequeue, unqueued ops, duplicates, clamps, extreme ticks
    add_req(REQ_DEQ, 0, 3, 0);
    add_req(REQ_REM, 63, 0, 0);
    add_req(REQ_DEM, 5, 0, 1);
    add_req(REQ_PRO, 5, 0, 1);
    add_req(REQ_REIN, 5, 0, 1);
    tick_now = 32'hFFFF_FFF0;
    add_req(REQ_ENQ, 63, 3, 1);
    add_req(REQ_ENQ, 0, 0, 0);
    add_req(REQ_ENQ, 63, 1, 0);
    add_req(REQ_DEM, 63, 0, 0);
    add_req(REQ_PRO, 0, 0, 0);
    add_req(REQ_PRO, 63, 0, 0);
    add_req(REQ_ENQ, 21, 2, 0);
    add_req(REQ_ENQ, 42, 2, 1);
    add_req(REQ_REIN, 21, 0, 1);
    add_req(REQ_REIN, 42, 0, 0);
    add_req(REQ_REM, 21, 0, 0);
    add_req(REQ_UNUSED_0, 17, 1, 1);
    add_req(REQ_UNUSED_1, 46, 2, 0);
    add_req(REQ_DEQ, 0, 2, 1);
    add_req(REQ_DEQ, 0, 0, 0);
    // one more dequeue at level 3, which is empty by now, before level 1 takes all of them
    add_req(REQ_DEQ, 0, 3, 0);
    // fill level 1 to full with all processes, then a dequeue, duplicate enqueues and a demotion
    for (int i = 0; i < NUM_PROCS; i++) add_req(REQ_ENQ, i, 1, 0);
    add_req(REQ_DEQ, 0, 1, 0);
    add_req(REQ_ENQ, 7, 1, 0);
    add_req(REQ_DEM, 9, 0, 0);
    add_req(REQ_ENQ, 10, 1, 0);
    for (int i = 1; i < NUM_PROCS; i++) add_req(REQ_DEQ, 0, 1, 1);

    // random: mostly valid ops on a few busy processes, with a stretch without idle gaps
    for (k = 0; k < 700; k++) begin
      sel = $urandom_range(0, 99);
      p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
      if (k == 300) begin
        wait (pending_reqs.size() == 0);
        no_idle = 1;
      end
      if (k == 450) begin
        wait (pending_reqs.size() == 0);
        no_idle = 0;
      end
      if ($urandom_range(0, 49) == 0) tick_now = $urandom;
      if (sel < 30) add_req(REQ_ENQ, p, $urandom_range(0, 3), $urandom_range(0, 1));
      else if (sel < 48) add_req(REQ_DEQ, $urandom_range(0, 63), $urandom_range(0, 3),
                                 $urandom_range(0, 1));
      else if (sel < 58) add_req(REQ_REM, p, $urandom_range(0, 3), $urandom_range(0, 1));
      else if (sel < 70) add_req(REQ_DEM, p, $urandom_range(0, 3), $urandom_range(0, 1));
      else if (sel < 82) add_req(REQ_PRO, p, $urandom_range(0, 3), $urandom_range(0, 1));
      else if (sel < 97) add_req(REQ_REIN, p, $urandom_range(0, 3), $urandom_range(0, 1));
      else add_req($urandom_range(REQ_UNUSED_0, REQ_UNUSED_1), p, $urandom_range(0, 3),
                   $urandom_range(0, 1));
    end

    wait (pending_reqs.size() == 0 && !(in_valid && !in_ready));
    @(posedge clk);
    wait (expected_rsps.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/mfqs_pkg.sv
hw/rtl/mfqs_ram.sv
hw/rtl/mfqs_dp.sv
hw/rtl/mfqs_ctrl.sv
hw/rtl/multilevel_feedback_queue_set_top.sv
tb/multilevel_feedback_queue_set_top_tb.sv
